// ===== rtl/imu_mag_gyro_conditioner_top_macros.svh =====
// ----------------------------------------------------------------------------
// IMU conditioner assertion macros
// Assertion helpers shared by the conditioner RTL; they compile away for
// synthesis when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IMU_MAG_GYRO_CONDITIONER_TOP_MACROS_SVH
`define IMU_MAG_GYRO_CONDITIONER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define IMC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define IMC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define IMC_ASSERT_IMP(lbl, ante, cons, msg)
`define IMC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/imc_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU conditioner package
// Widths, reset constants, register codes and shared types.
// ----------------------------------------------------------------------------
package imc_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int LIMIT_W      = 16;
	localparam int DEADBAND_W   = 15;
	localparam int PERIOD_W     = 24;
	localparam int YAW_W        = 48;
	localparam int PROD_W       = SAMPLE_WIDTH + PERIOD_W + 1;
	localparam int SUM_W        = YAW_W + 2;
	localparam int APB_AW       = 4;
	localparam int APB_DW       = 32;
	localparam int NUM_AXES     = 3;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [YAW_W-1:0]        yaw_t;
	typedef logic signed [PROD_W-1:0]       prod_t;

	localparam sample_t AXIS_MIN_RST = sample_t'((2 ** (SAMPLE_WIDTH - 1)) - 1);
	localparam sample_t AXIS_MAX_RST = sample_t'(-((2 ** (SAMPLE_WIDTH - 1)) - 1));

	localparam logic [LIMIT_W-1:0]    JUMP_LIMIT_RST = LIMIT_W'(30);
	localparam logic [DEADBAND_W-1:0] DEADBAND_RST   = DEADBAND_W'(1);
	localparam logic [PERIOD_W-1:0]   PERIOD_RST     = PERIOD_W'(655);

	typedef enum logic [1:0] {
		REG_CALIB_ENABLE  = 2'd0,
		REG_JUMP_LIMIT    = 2'd1,
		REG_RATE_DEADBAND = 2'd2,
		REG_PERIOD_Q16    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                  calib_enable;
		logic [LIMIT_W-1:0]    mag_jump_limit;
		logic [DEADBAND_W-1:0] rate_deadband;
		logic [PERIOD_W-1:0]   period_q16;
	} cfg_t;

	// Control handed to one magnetometer lane.
	typedef struct packed {
		logic take;
		logic track;
		logic commit;
	} lane_ctrl_t;

	// What one lane reports back to the merge logic.
	typedef struct packed {
		logic    in_range;
		sample_t min_v;
		sample_t max_v;
		sample_t acc_v;
	} lane_stat_t;

endpackage

// ===== rtl/imc_ifs.sv =====
// ----------------------------------------------------------------------------
// IMU conditioner channels
// Valid/ready interfaces for the sample and result channels.
// ----------------------------------------------------------------------------
interface imc_sample_if;
	import imc_pkg::*;

	logic    valid;
	logic    ready;
	sample_t gyro_z;
	sample_t mag_x;
	sample_t mag_y;
	sample_t mag_z;

	modport source (output valid, gyro_z, mag_x, mag_y, mag_z, input ready);
	modport sink (input valid, gyro_z, mag_x, mag_y, mag_z, output ready);
endinterface

interface imc_result_if;
	import imc_pkg::*;

	logic    valid;
	logic    ready;
	sample_t filt_mag_x;
	sample_t filt_mag_y;
	sample_t filt_mag_z;
	yaw_t    yaw_angle;
	sample_t min_x;
	sample_t min_y;
	sample_t min_z;
	sample_t max_x;
	sample_t max_y;
	sample_t max_z;

	modport source (output valid, filt_mag_x, filt_mag_y, filt_mag_z, yaw_angle,
		min_x, min_y, min_z, max_x, max_y, max_z, input ready);
	modport sink (input valid, filt_mag_x, filt_mag_y, filt_mag_z, yaw_angle,
		min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

// ===== rtl/imu_mag_gyro_conditioner_top.sv =====
// An accepted sample request passes through stage 1, then the output register.
// Throughput: one sample request per cycle; the rate product is registered in
// stage 1 and the combinational saturating yaw add feeds the output register
// (stage 2). The input stalls only while the stage 1 and output registers
// are full. Reset (arst_n low, asynchronous) clears the pipeline and restores
// the calibration extremes, the accepted vector, yaw and the config registers.
// ----------------------------------------------------------------------------
// IMU magnetometer and gyro conditioner, top level
// Three magnetometer lanes work side by side on the axes of one sample, a
// merge stage decides whether the spike filter accepts the vector, and a
// yaw unit integrates the gyro Z rate.
// ----------------------------------------------------------------------------
`include "imu_mag_gyro_conditioner_top_macros.svh"

module imu_mag_gyro_conditioner_top
	import imc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	imc_sample_if.sink        samples,
	imc_result_if.source      results
);

	cfg_t       cfg;
	sample_t    mag_in [NUM_AXES];
	lane_ctrl_t lane_ctrl;
	lane_stat_t lane_stat [NUM_AXES];
	logic       all_in_range;
	logic       take;
	logic       advance;
	logic       out_free;
	logic       acc_valid_q;
	logic       s1_valid_q;
	logic       out_valid_s2;
	yaw_t       yaw_nxt;
	yaw_t       yaw_cur;

	// Stage 1 holds the magnetometer state as it stood after this sample.
	sample_t    acc_s1 [NUM_AXES];
	sample_t    min_s1 [NUM_AXES];
	sample_t    max_s1 [NUM_AXES];

	// The output register.
	sample_t    acc_s2 [NUM_AXES];
	sample_t    min_s2 [NUM_AXES];
	sample_t    max_s2 [NUM_AXES];
	yaw_t       yaw_s2;

	imc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline flow: the output register frees when it is empty or being
	// taken, stage 1 moves on into it, and a new request enters whenever
	// stage 1 is empty or moving.
	assign out_free      = !out_valid_s2 || results.ready;
	assign advance       = s1_valid_q && out_free;
	assign samples.ready = !s1_valid_q || out_free;
	assign take          = samples.valid && samples.ready;

	assign mag_in[0] = samples.mag_x;
	assign mag_in[1] = samples.mag_y;
	assign mag_in[2] = samples.mag_z;

	// Merge: the vector is accepted only if every axis stayed within the
	// jump limit, and the first sample after reset is accepted as it is.
	always_comb begin
		all_in_range = 1'b1;
		for (int i = 0; i < NUM_AXES; i++) begin
			all_in_range = all_in_range && lane_stat[i].in_range;
		end
		lane_ctrl.take   = take;
		lane_ctrl.track  = cfg.calib_enable;
		lane_ctrl.commit = !acc_valid_q || all_in_range;
	end

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
		imc_mag_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.sample (mag_in[g]),
			.limit  (cfg.mag_jump_limit),
			.ctrl   (lane_ctrl),
			.stat   (lane_stat[g])
		);
	end

	imc_yaw_unit u_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.advance  (advance),
		.gyro     (samples.gyro_z),
		.deadband (cfg.rate_deadband),
		.period   (cfg.period_q16),
		.yaw_nxt  (yaw_nxt),
		.yaw_cur  (yaw_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_q  <= 1'b0;
			s1_valid_q   <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (take && lane_ctrl.commit) begin
				acc_valid_q <= 1'b1;
			end
			if (take) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_s2 <= 1'b1;
			end else if (results.ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				acc_s1[i] <= lane_stat[i].acc_v;
				min_s1[i] <= lane_stat[i].min_v;
				max_s1[i] <= lane_stat[i].max_v;
			end
		end
		if (advance) begin
			acc_s2 <= acc_s1;
			min_s2 <= min_s1;
			max_s2 <= max_s1;
			yaw_s2 <= yaw_nxt;
		end
	end

	assign results.valid      = out_valid_s2;
	assign results.filt_mag_x = acc_s2[0];
	assign results.filt_mag_y = acc_s2[1];
	assign results.filt_mag_z = acc_s2[2];
	assign results.yaw_angle  = yaw_s2;
	assign results.min_x      = min_s2[0];
	assign results.min_y      = min_s2[1];
	assign results.min_z      = min_s2[2];
	assign results.max_x      = max_s2[0];
	assign results.max_y      = max_s2[1];
	assign results.max_z      = max_s2[2];

	// A stage 1 entry that cannot move must still be there next cycle.
	`IMC_ASSERT_NXT(a_s1_hold, s1_valid_q && !advance, s1_valid_q, "stage 1 entry lost")
	// The yaw accumulator changes only when its request moves to the output.
	`IMC_ASSERT_NXT(a_yaw_stable, !advance, $stable(yaw_cur), "yaw moved without advance")
	// Once any request is accepted the spike filter has a reference vector.
	`IMC_ASSERT_NXT(a_acc_valid, take, acc_valid_q, "accepted vector not marked valid")
	// Moving stage 1 on always leaves a result in the output register.
	`IMC_ASSERT_NXT(a_out_fill, advance, results.valid, "advanced request not shown")

endmodule

// ===== rtl/imc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// IMU conditioner register file
// APB-style register bank holding the four configuration registers.
// ----------------------------------------------------------------------------
module imc_cfg_regs
	import imc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	// Registers are word aligned; the byte offset bits are ignored.
	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.calib_enable   <= 1'b0;
			cfg_q.mag_jump_limit <= JUMP_LIMIT_RST;
			cfg_q.rate_deadband  <= DEADBAND_RST;
			cfg_q.period_q16     <= PERIOD_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_CALIB_ENABLE:  cfg_q.calib_enable   <= pwdata[0];
				REG_JUMP_LIMIT:    cfg_q.mag_jump_limit <= pwdata[LIMIT_W-1:0];
				REG_RATE_DEADBAND: cfg_q.rate_deadband  <= pwdata[DEADBAND_W-1:0];
				REG_PERIOD_Q16:    cfg_q.period_q16     <= pwdata[PERIOD_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CALIB_ENABLE:  prdata = APB_DW'(cfg_q.calib_enable);
			REG_JUMP_LIMIT:    prdata = APB_DW'(cfg_q.mag_jump_limit);
			REG_RATE_DEADBAND: prdata = APB_DW'(cfg_q.rate_deadband);
			REG_PERIOD_Q16:    prdata = APB_DW'(cfg_q.period_q16);
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== rtl/imc_mag_lane.sv =====
// ----------------------------------------------------------------------------
// IMU conditioner magnetometer lane
// One axis: min/max tracking, spike check and the accepted value.
// ----------------------------------------------------------------------------
module imc_mag_lane
	import imc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  sample_t            sample,
	input  logic [LIMIT_W-1:0] limit,
	input  lane_ctrl_t         ctrl,
	output lane_stat_t         stat
);

	sample_t                   min_q;
	sample_t                   max_q;
	sample_t                   acc_q;
	logic signed [SAMPLE_WIDTH:0] diff;
	logic [SAMPLE_WIDTH:0]     gap_abs;

	// Distance to the accepted value, one bit wider so it never wraps.
	assign diff = $signed({sample[SAMPLE_WIDTH-1], sample})
		- $signed({acc_q[SAMPLE_WIDTH-1], acc_q});
	assign gap_abs = diff[SAMPLE_WIDTH] ? (SAMPLE_WIDTH + 1)'(-diff) : diff;

	always_comb begin
		stat.in_range = (gap_abs <= (SAMPLE_WIDTH + 1)'(limit));
		stat.min_v    = (ctrl.take && ctrl.track && (sample < min_q)) ? sample : min_q;
		stat.max_v    = (ctrl.take && ctrl.track && (sample > max_q)) ? sample : max_q;
		stat.acc_v    = (ctrl.take && ctrl.commit) ? sample : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= AXIS_MIN_RST;
			max_q <= AXIS_MAX_RST;
			acc_q <= '0;
		end else begin
			min_q <= stat.min_v;
			max_q <= stat.max_v;
			acc_q <= stat.acc_v;
		end
	end

endmodule

// ===== rtl/imc_yaw_unit.sv =====
// ----------------------------------------------------------------------------
// IMU conditioner yaw integrator
// Registered rate-times-period product and a saturating accumulator.
// ----------------------------------------------------------------------------
module imc_yaw_unit
	import imc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic                  advance,
	input  sample_t               gyro,
	input  logic [DEADBAND_W-1:0] deadband,
	input  logic [PERIOD_W-1:0]   period,
	output yaw_t                  yaw_nxt,
	output yaw_t                  yaw_cur
);

	localparam logic signed [SUM_W-1:0] YAW_HI = SUM_W'((longint'(1) <<< (YAW_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] YAW_LO = SUM_W'(-(longint'(1) <<< (YAW_W - 1)));

	prod_t                    prod_s1;
	logic                     active_s1;
	yaw_t                     yaw_q;
	logic [SAMPLE_WIDTH-1:0]  rate_mag;
	logic signed [SUM_W-1:0]  sum;

	// The most negative rate has a magnitude of 2^(w-1), which the unsigned
	// form holds exactly, so it always clears the deadband.
	assign rate_mag = gyro[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-gyro) : gyro;

	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1 <= PROD_W'(gyro) * PROD_W'($signed({1'b0, period}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_s1 <= 1'b0;
			yaw_q     <= '0;
		end else begin
			if (take) begin
				active_s1 <= ((SAMPLE_WIDTH + DEADBAND_W)'(rate_mag)
					> (SAMPLE_WIDTH + DEADBAND_W)'(deadband));
			end
			if (advance) begin
				yaw_q <= yaw_nxt;
			end
		end
	end

	assign sum = SUM_W'(yaw_q) + SUM_W'(prod_s1);

	always_comb begin
		priority if (!active_s1) begin
			yaw_nxt = yaw_q;
		end else if (sum > YAW_HI) begin
			yaw_nxt = YAW_HI[YAW_W-1:0];
		end else if (sum < YAW_LO) begin
			yaw_nxt = YAW_LO[YAW_W-1:0];
		end else begin
			yaw_nxt = sum[YAW_W-1:0];
		end
	end

	assign yaw_cur = yaw_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU magnetometer and gyro conditioner testbench
// Sends sample requests through a bursty driver, drains result requests with
// a stalling receiver and checks every field against an in-bench predictor
// of the spike filter, the min/max tracker and the saturating yaw integrator.
// ----------------------------------------------------------------------------
module tb;
	import imc_pkg::*;

	localparam longint YAW_TOP = (longint'(1) << (YAW_W - 1)) - 1;
	localparam longint YAW_BOT = -YAW_TOP - 1;

	// One sample request waiting to be driven. When hold is set the driver
	// keeps it back until every outstanding result has come home.
	typedef struct packed {
		sample_t gyro_z;
		sample_t mag_x;
		sample_t mag_y;
		sample_t mag_z;
		logic    hold;
	} sample_req_t;

	// The full set of fields a result request is expected to carry.
	typedef struct {
		sample_t filt[NUM_AXES];
		yaw_t    yaw;
		sample_t lo[NUM_AXES];
		sample_t hi[NUM_AXES];
	} cond_out_t;

	// Patterns the result receiver cycles through.
	typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_TRICKLE} rx_mode_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	imc_sample_if sample_ch ();
	imc_result_if result_ch ();

	imu_mag_gyro_conditioner_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (sample_ch),
		.results (result_ch)
	);

	// Requests still to be driven, and results owed by the block, oldest first.
	sample_req_t pending_samples[$];
	cond_out_t   owed_outputs[$];

	// The predictor's own copy of the register file.
	logic                  cfg_calib;
	logic [LIMIT_W-1:0]    cfg_limit;
	logic [DEADBAND_W-1:0] cfg_deadband;
	logic [PERIOD_W-1:0]   cfg_period;

	// The predictor's own copy of the block's state.
	sample_t trk_min[NUM_AXES];
	sample_t trk_max[NUM_AXES];
	sample_t held_mag[NUM_AXES];
	bit      held_valid;
	yaw_t    yaw_acc;

	// Bookkeeping for the end-of-run summary.
	int errors;
	int samples_taken;
	int results_checked;
	int spikes_dropped;
	int yaw_clips_high;
	int yaw_clips_low;
	int settings_used;

	// Driver and receiver pacing.
	bit       took;
	int       burst_left;
	int       gap_left;
	rx_mode_t rx_mode;
	int       rx_mode_left;
	int       rx_cycle;

	// Where the stimulus generator believes the accepted vector sits, so that
	// most random samples land within reach of the spike filter.
	int walk[NUM_AXES];

	// The clock runs at a 12 ns period.
	always #6 clk = ~clk;

	// Reset is held at the start of the run and never asserted again.
	// Every input of the block is given a known value at time zero.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.gyro_z = '0;
		sample_ch.mag_x = '0;
		sample_ch.mag_y = '0;
		sample_ch.mag_z = '0;
		result_ch.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Predicts the result of one accepted sample and advances the predictor's
	// state. The min/max update comes first, then the spike filter against
	// the previously accepted vector, then the yaw integration.
	function automatic cond_out_t condition_sample(sample_t g, sample_t mx, sample_t my,
			sample_t mz);
		cond_out_t o;
		sample_t   m[NUM_AXES];
		bit        take;
		int        d;
		int        rate_mag;
		longint    sum;
		m[0] = mx;
		m[1] = my;
		m[2] = mz;
		take = 1'b1;
		for (int i = 0; i < NUM_AXES; i++) begin
			if (cfg_calib) begin
				if (m[i] < trk_min[i])
					trk_min[i] = m[i];
				if (m[i] > trk_max[i])
					trk_max[i] = m[i];
			end
			// The first sample after reset has nothing to be compared with.
			d = int'(m[i]) - int'(held_mag[i]);
			if (d < 0)
				d = -d;
			if (held_valid && d > int'(cfg_limit))
				take = 1'b0;
		end
		if (take) begin
			held_mag = m;
			held_valid = 1'b1;
		end else begin
			spikes_dropped++;
		end
		// The most negative rate has a magnitude one past the positive range,
		// so it clears any deadband.
		rate_mag = (g < 0) ? -int'(g) : int'(g);
		if (rate_mag > int'(cfg_deadband)) begin
			sum = longint'(yaw_acc) + longint'(g) * longint'(cfg_period);
			if (sum > YAW_TOP) begin
				sum = YAW_TOP;
				yaw_clips_high++;
			end
			if (sum < YAW_BOT) begin
				sum = YAW_BOT;
				yaw_clips_low++;
			end
			yaw_acc = yaw_t'(sum);
		end
		o.filt = held_mag;
		o.lo = trk_min;
		o.hi = trk_max;
		o.yaw = yaw_acc;
		return o;
	endfunction

	task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Checker and predictor share one block so that a result seen at an edge
	// is always matched before a request accepted at that same edge is queued.
	always @(posedge clk) begin
		cond_out_t want;
		sample_t   got_filt[NUM_AXES];
		sample_t   got_lo[NUM_AXES];
		sample_t   got_hi[NUM_AXES];
		string     axis_tag[NUM_AXES];
		if (!arst_n) begin
			took = 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (owed_outputs.size() == 0) begin
					$error("result request arrived with nothing outstanding");
					errors++;
				end else begin
					want = owed_outputs.pop_front();
					axis_tag = '{"x", "y", "z"};
					got_filt = '{result_ch.filt_mag_x, result_ch.filt_mag_y,
						result_ch.filt_mag_z};
					got_lo = '{result_ch.min_x, result_ch.min_y, result_ch.min_z};
					got_hi = '{result_ch.max_x, result_ch.max_y, result_ch.max_z};
					for (int i = 0; i < NUM_AXES; i++) begin
						check_field({"filt_mag_", axis_tag[i]}, want.filt[i], got_filt[i]);
						check_field({"min_", axis_tag[i]}, want.lo[i], got_lo[i]);
						check_field({"max_", axis_tag[i]}, want.hi[i], got_hi[i]);
					end
					check_field("yaw_angle", want.yaw, result_ch.yaw_angle);
					results_checked++;
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				owed_outputs.push_back(condition_sample(sample_ch.gyro_z, sample_ch.mag_x,
					sample_ch.mag_y, sample_ch.mag_z));
				samples_taken++;
				took = 1'b1;
			end
		end
	end

	// Sample driver. It works in bursts separated by random gaps, with the
	// occasional long burst that runs back to back. A request marked hold is
	// not offered until the result side has fully drained.
	always @(negedge clk) begin
		sample_req_t nxt;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!sample_ch.valid || took) begin
			took = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				sample_ch.valid <= 1'b0;
			end else if (pending_samples.size() == 0 ||
					(pending_samples[0].hold && owed_outputs.size() != 0)) begin
				sample_ch.valid <= 1'b0;
			end else begin
				nxt = pending_samples.pop_front();
				sample_ch.gyro_z <= nxt.gyro_z;
				sample_ch.mag_x <= nxt.mag_x;
				sample_ch.mag_y <= nxt.mag_y;
				sample_ch.mag_z <= nxt.mag_z;
				sample_ch.valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else if ($urandom_range(0, 3) == 0) begin
					burst_left = $urandom_range(100, 250);
					gap_left = 0;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = $urandom_range(1, 10);
				end
			end
		end
	end

	// Result receiver. Each mode lasts a random stretch: always ready, a coin
	// toss, ready one cycle in four, or a slow trickle.
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(20, 200);
		end
		rx_mode_left--;
		rx_cycle++;
		case (rx_mode)
			RX_OPEN: begin
				result_ch.ready <= 1'b1;
			end
			RX_COIN: begin
				result_ch.ready <= 1'($urandom_range(0, 1));
			end
			RX_EVERY_FOURTH: begin
				result_ch.ready <= (rx_cycle % 4 == 0);
			end
			default: begin
				result_ch.ready <= ($urandom_range(0, 15) == 0);
			end
		endcase
	end

	// One register write: a setup cycle, then an access cycle that lands at
	// the edge where pready is seen high. Bits above the register's width
	// carry random junk, which the block must ignore.
	task automatic write_reg(reg_idx_t idx, int unsigned val);
		logic [APB_DW-1:0] keep;
		logic [APB_DW-1:0] word;
		case (idx)
			REG_CALIB_ENABLE: keep = 32'h1;
			REG_JUMP_LIMIT: keep = 32'hFFFF;
			REG_RATE_DEADBAND: keep = 32'h7FFF;
			default: keep = 32'hFF_FFFF;
		endcase
		word = (val & keep) | ($urandom() & ~keep);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * int'(idx));
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_CALIB_ENABLE: cfg_calib = word[0];
			REG_JUMP_LIMIT: cfg_limit = word[LIMIT_W-1:0];
			REG_RATE_DEADBAND: cfg_deadband = word[DEADBAND_W-1:0];
			default: cfg_period = word[PERIOD_W-1:0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_settings(int unsigned calib, int unsigned limit,
			int unsigned deadband, int unsigned period);
		write_reg(REG_CALIB_ENABLE, calib);
		write_reg(REG_JUMP_LIMIT, limit);
		write_reg(REG_RATE_DEADBAND, deadband);
		write_reg(REG_PERIOD_Q16, period);
		settings_used++;
	endtask

	// Waits until every queued request has gone in and every result has come
	// back, then lets the pipeline settle.
	task automatic drain();
		while (pending_samples.size() != 0 || sample_ch.valid || owed_outputs.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic queue_sample(int g, int x, int y, int z, bit hold);
		pending_samples.push_back('{gyro_z: sample_t'(g), mag_x: sample_t'(x),
			mag_y: sample_t'(y), mag_z: sample_t'(z), hold: hold});
	endtask

	function automatic int clamp16(int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	// Gyro rates: mostly anything at all, sometimes the extremes and the
	// values on either side of the deadband.
	function automatic int pick_rate();
		int db;
		db = int'(cfg_deadband);
		case ($urandom_range(0, 19))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return ($urandom_range(0, 1) != 0) ? db : -db;
			4: return clamp16(($urandom_range(0, 1) != 0) ? db + 1 : -db - 1);
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// Most magnetometer vectors stay within reach of the filter. Some put one
	// axis exactly on the limit or one past it, and some are wild spikes.
	task automatic queue_random_sample(int rate, bit hold);
		int v[NUM_AXES];
		int span;
		int kind;
		int ax;
		kind = $urandom_range(0, 19);
		span = (cfg_limit > 1500) ? 1500 : int'(cfg_limit);
		for (int i = 0; i < NUM_AXES; i++)
			v[i] = clamp16(walk[i] + int'($urandom_range(0, 2 * span)) - span);
		ax = $urandom_range(0, NUM_AXES - 1);
		if (kind < 2) begin
			for (int i = 0; i < NUM_AXES; i++)
				v[i] = int'($urandom_range(0, 65535)) - 32768;
		end else if (kind == 2) begin
			v[ax] = clamp16(walk[ax] + int'(cfg_limit));
		end else if (kind == 3) begin
			v[ax] = clamp16(walk[ax] - int'(cfg_limit) - 1);
		end
		if (kind >= 4 || kind == 2)
			walk = v;
		queue_sample(rate, v[0], v[1], v[2], hold);
	endtask

	initial begin
		for (int i = 0; i < NUM_AXES; i++) begin
			trk_min[i] = AXIS_MIN_RST;
			trk_max[i] = AXIS_MAX_RST;
			held_mag[i] = '0;
			walk[i] = 0;
		end
		held_valid = 1'b0;
		yaw_acc = '0;
		cfg_calib = 1'b0;
		cfg_limit = JUMP_LIMIT_RST;
		cfg_deadband = DEADBAND_RST;
		cfg_period = PERIOD_RST;
		errors = 0;
		samples_taken = 0;
		results_checked = 0;
		spikes_dropped = 0;
		yaw_clips_high = 0;
		yaw_clips_low = 0;
		settings_used = 1;
		took = 1'b0;
		burst_left = 0;
		gap_left = 0;
		rx_mode = RX_OPEN;
		rx_mode_left = 0;
		rx_cycle = 0;
		wait (arst_n === 1'b1);

		// Out of reset: calibration is off, so min/max hold their reset values.
		// The first sample is wild and still accepted; the rate at the negative
		// extreme is integrated, a rate equal to the deadband is not.
		queue_sample(-32768, 32767, -32768, 12345, 1'b0);
		queue_sample(1, 32737, -32738, 12375, 1'b0);
		// One axis one past the jump limit, then all three one past it.
		queue_sample(-1, 32737, -32738, 12406, 1'b0);
		queue_sample(2, 32706, -32707, 12344, 1'b0);
		// Every axis exactly on the limit is accepted.
		queue_sample(-2, 32707, -32708, 12345, 1'b0);
		queue_sample(32767, 0, 0, 0, 1'b0);
		queue_sample(0, 32707, -32708, 12345, 1'b1);
		drain();

		// Calibration on, zero jump limit, zero deadband and a zero period, so
		// every nonzero rate passes the deadband but adds nothing.
		program_settings(1, 0, 0, 0);
		queue_sample(32767, 32707, -32708, 12345, 1'b0);
		queue_sample(-32768, 32708, -32708, 12345, 1'b0);
		queue_sample(0, -32768, -32768, -32768, 1'b0);
		queue_sample(0, 32767, 32767, 32767, 1'b0);
		queue_sample(-1, -1, 0, 1, 1'b0);
		drain();

		// Largest limit, deadband and period: a full-scale swing still passes
		// the filter, and only the most negative rate beats the deadband.
		program_settings(1, 16'hFFFF, 15'h7FFF, 24'hFF_FFFF);
		queue_sample(32767, -32768, 32767, 0, 1'b0);
		queue_sample(-32768, 32767, -32768, -1, 1'b0);
		queue_sample(-32767, -32768, 32767, 21845, 1'b0);
		queue_sample(32766, -21846, 10922, -10923, 1'b0);
		drain();

		// Random settings with a tight filter; the phase opens with a request
		// that waits for the pipeline to run dry.
		program_settings(1, $urandom_range(0, 64), $urandom_range(0, 50),
			$urandom_range(0, 24'hFF_FFFF));
		for (int n = 0; n < 220; n++)
			queue_random_sample(pick_rate(), n == 0 || $urandom_range(0, 99) == 0);
		drain();

		// Full-scale period with no deadband: a long run of large positive rates
		// drives yaw into its upper clip, then a longer negative run takes it
		// through to the lower one.
		program_settings($urandom_range(0, 1), $urandom_range(0, 4096), 0, 24'hFF_FFFF);
		for (int n = 0; n < 320; n++)
			queue_random_sample($urandom_range(28000, 32767), $urandom_range(0, 99) == 0);
		for (int n = 0; n < 620; n++)
			queue_random_sample(-int'($urandom_range(28000, 32768)),
				$urandom_range(0, 99) == 0);
		drain();

		// Calibration off, zero limit so that only exact repeats pass, and the
		// widest deadband.
		program_settings(0, 0, 15'h7FFF, $urandom_range(0, 24'hFF_FFFF));
		for (int n = 0; n < 120; n++)
			queue_random_sample(pick_rate(), n == 0);
		drain();

		// Everything random across its full range.
		program_settings(1, $urandom_range(0, 16'hFFFF), $urandom_range(0, 15'h7FFF),
			$urandom_range(0, 24'hFF_FFFF));
		for (int n = 0; n < 120; n++)
			queue_random_sample(pick_rate(), $urandom_range(0, 99) == 0);
		drain();
		repeat (10) @(posedge clk);

		$display("Run covered %0d sample requests and %0d checked results over %0d settings.",
			samples_taken, results_checked, settings_used);
		$display("Spike filter dropped %0d vectors; yaw clipped high %0d and low %0d times.",
			spikes_dropped, yaw_clips_high, yaw_clips_low);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Safety net: a hung handshake ends the run here.
	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
